// File: hdl/bda_pkg.sv
// ----------------------------------------------------------------------------
// bda_pkg: shared types and constants for the button debounce block
// Register indexes, configuration defaults and stream field positions.
// ----------------------------------------------------------------------------
package bda_pkg;

    // configuration register width and defaults
    localparam int CFG_W               = 16;
    localparam int CFG_IDX_W           = 2;
    localparam int DEFAULT_COUNT_WIDTH = 16;

    localparam logic [CFG_W-1:0] RST_DEBOUNCE        = 16'd50;
    localparam logic [CFG_W-1:0] RST_REPEAT_START    = 16'd500;
    localparam logic [CFG_W-1:0] RST_REPEAT_INTERVAL = 16'd100;

    // stream widths (whole bytes) and result field width
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 8;
    localparam int RESULT_W    = 3;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE        = 2'd0,
        CFG_REPEAT_START    = 2'd1,
        CFG_REPEAT_INTERVAL = 2'd2
    } t_cfg_idx;

    // configuration set seen by the step logic
    typedef struct packed {
        logic [CFG_W-1:0] debounce_ticks;
        logic [CFG_W-1:0] repeat_start_ticks;
        logic [CFG_W-1:0] repeat_interval_ticks;
    } t_cfg;

    // one result, packed as in the output tdata (highest bit first)
    typedef struct packed {
        logic repeat_pulse;
        logic click;
        logic pressed;
    } t_result;

endpackage

// File: hdl/bda_step.sv
// ----------------------------------------------------------------------------
// bda_step: next-state logic for one tick
// Advances the stability and hold counters, accepts press or release and
// evaluates the auto-repeat rule. Purely combinational.
// ----------------------------------------------------------------------------
module bda_step #(
    parameter int COUNT_WIDTH = bda_pkg::DEFAULT_COUNT_WIDTH
) (
    input  bda_pkg::t_cfg           i_cfg,
    input  logic                    i_raw,
    input  logic                    i_last_raw,
    input  logic [COUNT_WIDTH-1:0]  i_stable_age,
    input  logic                    i_is_pressed,
    input  logic [COUNT_WIDTH-1:0]  i_hold_age,
    input  logic [COUNT_WIDTH-1:0]  i_since_repeat,
    input  logic                    i_was_held,
    output logic                    o_last_raw,
    output logic [COUNT_WIDTH-1:0]  o_stable_age,
    output logic                    o_is_pressed,
    output logic [COUNT_WIDTH-1:0]  o_hold_age,
    output logic [COUNT_WIDTH-1:0]  o_since_repeat,
    output logic                    o_was_held,
    output bda_pkg::t_result        o_result
);
    import bda_pkg::*;

    // compare width covers both counter and register
    localparam int CMP_W = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;

    logic [COUNT_WIDTH-1:0] hold_inc;
    logic [COUNT_WIDTH-1:0] since_inc;
    logic [COUNT_WIDTH-1:0] stable_nxt;
    logic                   level_ok;

    // saturating advance of the hold counters while pressed
    always_comb begin
        hold_inc  = i_hold_age;
        since_inc = i_since_repeat;
        if (i_is_pressed) begin
            if (i_hold_age != {COUNT_WIDTH{1'b1}}) begin
                hold_inc = i_hold_age + 1'b1;
            end
            if (i_since_repeat != {COUNT_WIDTH{1'b1}}) begin
                since_inc = i_since_repeat + 1'b1;
            end
        end
    end

    // stability counter: restart on a level change, else saturate upward
    always_comb begin
        if (i_raw != i_last_raw) begin
            stable_nxt = '0;
        end else if (i_stable_age == {COUNT_WIDTH{1'b1}}) begin
            stable_nxt = i_stable_age;
        end else begin
            stable_nxt = i_stable_age + 1'b1;
        end
    end

    assign level_ok = CMP_W'(stable_nxt) > CMP_W'(i_cfg.debounce_ticks);

    // press / release acceptance, then the repeat rule on the new state
    always_comb begin
        o_last_raw      = i_raw;
        o_stable_age    = stable_nxt;
        o_is_pressed    = i_is_pressed;
        o_hold_age      = hold_inc;
        o_since_repeat  = since_inc;
        o_was_held      = i_was_held;
        o_result        = '0;

        if (level_ok && !i_raw && !i_is_pressed) begin
            o_is_pressed   = 1'b1;
            o_hold_age     = '0;
            o_since_repeat = '0;
            o_was_held     = 1'b0;
        end else if (level_ok && i_raw && i_is_pressed) begin
            o_is_pressed   = 1'b0;
            o_result.click = !i_was_held;
        end

        if (o_is_pressed
            && CMP_W'(o_hold_age) >= CMP_W'(i_cfg.repeat_start_ticks)
            && CMP_W'(o_since_repeat) >= CMP_W'(i_cfg.repeat_interval_ticks)) begin
            o_since_repeat        = '0;
            o_was_held            = 1'b1;
            o_result.repeat_pulse = 1'b1;
        end

        o_result.pressed = o_is_pressed;
    end

endmodule

// File: hdl/button_debounce_autorepeat.sv
// ----------------------------------------------------------------------------
// button_debounce_autorepeat: switch debounce with auto-repeat
// One request per millisecond tick in, one result per tick out.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: each request is one tick; tdata[0] is the raw active-low
//   switch level (0 pressed, 1 released).
//   Master stream: one result per request; tdata[0] pressed, [1] click,
//   [2] repeat_pulse.
//   Config port: write enable, index (0 debounce, 1 repeat start,
//   2 repeat interval) and 16-bit data; index 3 is ignored. Write only
//   while no result is outstanding.
//   Latency: a result is valid the cycle after its request is accepted.
//   Throughput: one request per cycle unless the result register is stalled;
//   the state update is a single registered pass through the counter compare logic.
//   Reset (synchronous, active low): registers take their defaults (50,
//   500, 100), the switch is taken as released and the output is empty.
//   Stall: the result register holds while i_m_axis_tready is low; a new
//   request is taken only if the result register is empty or drains in
//   the same cycle.
// ----------------------------------------------------------------------------
module button_debounce_autorepeat #(
    parameter int COUNT_WIDTH = bda_pkg::DEFAULT_COUNT_WIDTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // config write port
    input  logic                            i_cfg_we,
    input  logic [bda_pkg::CFG_IDX_W-1:0]   i_cfg_addr,
    input  logic [bda_pkg::CFG_W-1:0]       i_cfg_wdata,
    // tick stream in
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [bda_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,  // [0] raw_level
    // result stream out
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [bda_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata   // [0] pressed, [1] click,
                                                             // [2] repeat_pulse
);
    import bda_pkg::*;

    t_cfg                   r_cfg;
    logic                   r_last_raw;
    logic [COUNT_WIDTH-1:0] r_stable_age;
    logic                   r_is_pressed;
    logic [COUNT_WIDTH-1:0] r_hold_age;
    logic [COUNT_WIDTH-1:0] r_since_repeat;
    logic                   r_was_held;
    logic                   r_out_valid;
    t_result                r_out;

    logic                   n_last_raw;
    logic [COUNT_WIDTH-1:0] n_stable_age;
    logic                   n_is_pressed;
    logic [COUNT_WIDTH-1:0] n_hold_age;
    logic [COUNT_WIDTH-1:0] n_since_repeat;
    logic                   n_was_held;
    t_result                n_out;
    logic                   in_fire;

    // accept while the result register is empty or being drained
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign in_fire         = i_s_axis_tvalid && o_s_axis_tready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ticks        <= RST_DEBOUNCE;
            r_cfg.repeat_start_ticks    <= RST_REPEAT_START;
            r_cfg.repeat_interval_ticks <= RST_REPEAT_INTERVAL;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_DEBOUNCE:        r_cfg.debounce_ticks        <= i_cfg_wdata;
                CFG_REPEAT_START:    r_cfg.repeat_start_ticks    <= i_cfg_wdata;
                CFG_REPEAT_INTERVAL: r_cfg.repeat_interval_ticks <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    bda_step #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_step (
        .i_cfg          (r_cfg),
        .i_raw          (i_s_axis_tdata[0]),
        .i_last_raw     (r_last_raw),
        .i_stable_age   (r_stable_age),
        .i_is_pressed   (r_is_pressed),
        .i_hold_age     (r_hold_age),
        .i_since_repeat (r_since_repeat),
        .i_was_held     (r_was_held),
        .o_last_raw     (n_last_raw),
        .o_stable_age   (n_stable_age),
        .o_is_pressed   (n_is_pressed),
        .o_hold_age     (n_hold_age),
        .o_since_repeat (n_since_repeat),
        .o_was_held     (n_was_held),
        .o_result       (n_out)
    );

    // tick state, updated once per accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_raw     <= 1'b1;
            r_stable_age   <= '0;
            r_is_pressed   <= 1'b0;
            r_hold_age     <= '0;
            r_since_repeat <= '0;
            r_was_held     <= 1'b0;
        end else if (in_fire) begin
            r_last_raw     <= n_last_raw;
            r_stable_age   <= n_stable_age;
            r_is_pressed   <= n_is_pressed;
            r_hold_age     <= n_hold_age;
            r_since_repeat <= n_since_repeat;
            r_was_held     <= n_was_held;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out <= n_out;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(OUT_TDATA_W-RESULT_W){1'b0}}, r_out};

endmodule

// File: hdl/bda_checker.sv
// ----------------------------------------------------------------------------
// bda_checker: port-level checks for button_debounce_autorepeat
// Watches the top-level streams; bound to the top level below.
// ----------------------------------------------------------------------------
module bda_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_axis_tvalid,
    input logic                            o_s_axis_tready,
    input logic                            o_m_axis_tvalid,
    input logic                            i_m_axis_tready,
    input logic [bda_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata
);
    import bda_pkg::*;

    // a click comes only with the released state
    a_click_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[1]) |-> !o_m_axis_tdata[0])
        else $error("click reported while pressed");

    // a repeat fires only while pressed, never with a click
    a_repeat_pressed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[2]) |-> (o_m_axis_tdata[0] && !o_m_axis_tdata[1]))
        else $error("repeat pulse while released");

    // every accepted request shows a result the next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> o_m_axis_tvalid)
        else $error("accepted request produced no result");

    // an empty result register never blocks the input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input stalled with empty output");

    // stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> (o_m_axis_tvalid && $stable(o_m_axis_tdata)))
        else $error("stalled result changed");

endmodule

bind button_debounce_autorepeat bda_checker u_bda_checker (.*);
